// ===== rtl/sfms_pkg.sv =====
// ----------------------------------------------------------------------------
// sfms_pkg: shared types and helpers for the substring search
// Register codes, field widths and the needle byte lookup.
// ----------------------------------------------------------------------------
package sfms_pkg;

	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 5;
	localparam int WORD_W  = 64;
	localparam int INDEX_W = 32;
	localparam int REG_W   = 2;
	localparam int NEEDLE_REG_BYTES = 8;

	typedef enum logic [REG_W-1:0] {
		REG_NEEDLE_LENGTH = 2'd0,
		REG_NEEDLE_LOW    = 2'd1,
		REG_NEEDLE_HIGH   = 2'd2,
		REG_UNUSED        = 2'd3
	} reg_index_t;

	typedef logic [BYTE_W-1:0]  byte_t;
	typedef logic [LEN_W-1:0]   len_t;
	typedef logic [WORD_W-1:0]  word_t;
	typedef logic [INDEX_W-1:0] index_t;

	// needle byte idx; positions past the two registers read as zero
	function automatic byte_t pat_byte(input word_t lo, input word_t hi, input len_t idx);
		byte_t r;
		if (idx < len_t'(NEEDLE_REG_BYTES)) begin
			r = lo[{idx[2:0], 3'b000} +: BYTE_W];
		end else if (idx < len_t'(2 * NEEDLE_REG_BYTES)) begin
			r = hi[{idx[2:0], 3'b000} +: BYTE_W];
		end else begin
			r = '0;
		end
		return r;
	endfunction

endpackage

// ===== rtl/sfms_ifs.sv =====
// ----------------------------------------------------------------------------
// sfms channel interfaces
// Valid/ready channels for text bytes in and search results out.
// ----------------------------------------------------------------------------
interface sfms_text_if;
	logic                       valid;
	logic                       ready;
	logic [sfms_pkg::BYTE_W-1:0] text_byte;
	logic                       final_byte;

	modport source (output valid, output text_byte, output final_byte, input ready);
	modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface sfms_result_if;
	logic                         valid;
	logic                         ready;
	logic                         found;
	logic [sfms_pkg::INDEX_W-1:0] match_index;

	modport source (output valid, output found, output match_index, input ready);
	modport sink   (input valid, input found, input match_index, output ready);
endinterface

// ===== rtl/sfms_cell.sv =====
// ----------------------------------------------------------------------------
// sfms_cell: one window cell
// Holds one past text byte, passes it on to its neighbor on every shift
// (a clear zeroes it) and compares it with its aligned needle byte.
// ----------------------------------------------------------------------------
module sfms_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  shift,
	input  logic                  clear,
	input  logic [sfms_pkg::BYTE_W-1:0] byte_in,
	input  logic                  active,
	input  logic [sfms_pkg::BYTE_W-1:0] expected,
	output logic [sfms_pkg::BYTE_W-1:0] byte_q,
	output logic                  match
);
	import sfms_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (clear) begin
			byte_q <= '0;
		end else if (shift) begin
			byte_q <= byte_in;
		end
	end

	// inactive cells lie outside the needle and never veto
	assign match = !active || (byte_q == expected);

endmodule

// ===== rtl/substring_first_match_search.sv =====
// ----------------------------------------------------------------------------
// substring_first_match_search: streaming first-occurrence substring search
// Chain of byte cells compared in parallel with a configured needle.
// ----------------------------------------------------------------------------
// Text enters one byte per transaction; final_byte marks a text's last byte.
// A byte is taken every cycle unless a full output register stalls: the
// whole window compare, the position count and the start index are settled
// in the accepting cycle and the result lands in a single output register;
// the input stays ready while that register is empty or being drained. At
// most one result per text: found with the lowest start index, or not-found
// on the final byte. An empty needle hits at index 0 on the first byte. The
// user must write the needle registers only while idle; nothing enforces it.
// ----------------------------------------------------------------------------
module substring_first_match_search #(
	parameter int MAX_NEEDLE = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sfms_pkg::REG_W-1:0]    cfg_index,
	input  logic [sfms_pkg::WORD_W-1:0]   cfg_wdata,
	sfms_text_if.sink                     text,
	sfms_result_if.source                 result
);
	import sfms_pkg::*;

	// configuration registers
	len_t  needle_len_q;
	word_t needle_lo_q;
	word_t needle_hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_len_q <= '0;
			needle_lo_q  <= '0;
			needle_hi_q  <= '0;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_NEEDLE_LENGTH: needle_len_q <= cfg_wdata[LEN_W-1:0];
				REG_NEEDLE_LOW:    needle_lo_q  <= cfg_wdata;
				REG_NEEDLE_HIGH:   needle_hi_q  <= cfg_wdata;
				default:           ; // unused index: write dropped
			endcase
		end
	end

	// needle length in use, clamped to the cell count
	len_t k;
	assign k = (int'(needle_len_q) > MAX_NEEDLE) ? len_t'(MAX_NEEDLE) : needle_len_q;

	// handshake
	logic res_valid_q;
	logic accept;
	assign text.ready = !res_valid_q || result.ready;
	assign accept     = text.valid && text.ready;

	// per-text state
	index_t count_q;
	logic   reported_q;

	// window cells: cell j holds the byte j+1 positions back
	byte_t win [MAX_NEEDLE];
	logic [MAX_NEEDLE-1:0] cell_match;

	for (genvar j = 0; j < MAX_NEEDLE; j++) begin : g_cell
		byte_t shift_in;
		logic  active;
		byte_t expected;
		if (j == 0) begin : g_head
			assign shift_in = text.text_byte;
		end else begin : g_link
			assign shift_in = win[j-1];
		end
		// cell j lines up with needle byte k-2-j
		assign active   = int'(k) > j + 1;
		assign expected = pat_byte(needle_lo_q, needle_hi_q, len_t'(int'(k) - j - 2));

		sfms_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift    (accept && !text.final_byte),
			.clear    (accept && text.final_byte),
			.byte_in  (shift_in),
			.active   (active),
			.expected (expected),
			.byte_q   (win[j]),
			.match    (cell_match[j])
		);
	end

	// match decision for the incoming byte
	logic   hit;
	index_t start;
	always_comb begin
		if (k == '0) begin
			hit   = 1'b1;
			start = '0;
		end else begin
			hit   = (count_q >= index_t'(k - len_t'(1)))
			     && (text.text_byte == pat_byte(needle_lo_q, needle_hi_q, k - len_t'(1)))
			     && (&cell_match);
			start = count_q - index_t'(k - len_t'(1));
		end
	end

	logic emit;
	assign emit = accept && !reported_q && (hit || text.final_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			reported_q <= 1'b0;
		end else if (accept) begin
			if (text.final_byte) begin
				count_q    <= '0;
				reported_q <= 1'b0;
			end else begin
				if (count_q != '1) begin
					count_q <= count_q + index_t'(1);
				end
				if (hit) begin
					reported_q <= 1'b1;
				end
			end
		end
	end

	// output register
	logic   found_q;
	index_t index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			found_q <= hit;
			index_q <= hit ? start : '0;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.found       = found_q;
	assign result.match_index = index_q;

endmodule

// ===== rtl/sfms_checker.sv =====
// ----------------------------------------------------------------------------
// sfms_checker: port-level checks for the substring search
// Watches both channels of the top level over time.
// ----------------------------------------------------------------------------
module sfms_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         text_valid,
	input logic                         text_ready,
	input logic                         res_valid,
	input logic                         res_ready,
	input logic                         res_found,
	input logic [sfms_pkg::INDEX_W-1:0] res_index
);
	import sfms_pkg::*;

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_found) && $stable(res_index))
		else $error("result changed while stalled");

	// not-found carries a zero index
	a_nf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_found |-> res_index == '0)
		else $error("not-found result with nonzero index");

	// input never blocked by an empty output register
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> text_ready)
		else $error("input stalled with empty output");

	// a result only follows an accepted byte
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid ##1 res_valid |-> $past(text_valid && text_ready))
		else $error("result without a text transaction");

	// a drained result with no new text transaction leaves the output empty
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !(text_valid && text_ready) |=> !res_valid)
		else $error("result repeated after it was taken");

endmodule

bind substring_first_match_search sfms_checker u_sfms_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.text_valid (text.valid),
	.text_ready (text.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_found  (result.found),
	.res_index  (result.match_index)
);

// ===== dv/first_match_checker.sv =====
// ----------------------------------------------------------------------------
// first_match_checker: predictor and result checker for the substring search
// Watches the config port and both channels, predicts the first-match result
// of every text and compares accepted results in order.
// ----------------------------------------------------------------------------
module first_match_checker #(
	parameter int MAX_NEEDLE = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sfms_pkg::REG_W-1:0]    cfg_index,
	input  sfms_pkg::word_t               cfg_wdata,
	sfms_text_if                          text_mon,
	sfms_result_if                        result_mon,
	output int                            errors,
	output int                            pending,
	output int                            found_seen,
	output int                            missed_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	import sfms_pkg::*;

	typedef struct packed {
		logic   found;
		index_t start;
	} search_result_t;

	// mirrored needle registers
	len_t  needle_len;
	word_t needle_lo;
	word_t needle_hi;

	// per-text search state
	byte_t  history [MAX_NEEDLE-1];
	index_t text_pos;
	logic   reported;

	search_result_t expected_results[$];

	task automatic report(string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin : predict_and_check
		int unsigned k;
		logic hit;
		index_t start;
		byte_t probe;
		byte_t want;
		logic [8*MAX_NEEDLE+2*WORD_W-1:0] needle_bits;
		search_result_t got;
		search_result_t exp;
		if (!arst_n) begin
			needle_len = '0;
			needle_lo = '0;
			needle_hi = '0;
			history = '{default: '0};
			text_pos = '0;
			reported = 1'b0;
			expected_results.delete();
			pending = 0;
		end else begin
			// a result taken now was predicted at an earlier edge
			if (result_mon.valid && result_mon.ready) begin
				got.found = result_mon.found;
				got.start = result_mon.match_index;
				if (expected_results.size() == 0) begin
					report($sformatf("result found=%0b index=%0d with none expected",
						got.found, got.start));
				end else begin
					exp = expected_results.pop_front();
					if (got.found !== exp.found)
						report($sformatf("found=%0b, expected %0b", got.found, exp.found));
					if (got.start !== exp.start)
						report($sformatf("match_index=%0d, expected %0d",
							got.start, exp.start));
					if (exp.found)
						found_seen++;
					else
						missed_seen++;
				end
			end

			if (cfg_we) begin
				case (cfg_index)
					REG_NEEDLE_LENGTH: needle_len = cfg_wdata[LEN_W-1:0];
					REG_NEEDLE_LOW:    needle_lo = cfg_wdata;
					REG_NEEDLE_HIGH:   needle_hi = cfg_wdata;
					default: ;
				endcase
			end

			if (text_mon.valid && text_mon.ready) begin
				k = (int'(needle_len) > MAX_NEEDLE) ? MAX_NEEDLE : needle_len;
				// bytes past the two needle registers read as zero
				needle_bits = {{(8*MAX_NEEDLE){1'b0}}, needle_hi, needle_lo};
				hit = 1'b0;
				start = '0;
				if (k == 0) begin
					hit = 1'b1;
				end else if (text_pos >= index_t'(k - 1)) begin
					// newest byte lines up with the needle's last byte
					hit = 1'b1;
					for (int d = 0; d < k; d++) begin
						probe = text_mon.text_byte;
						if (d != 0)
							probe = history[d-1];
						want = needle_bits[8*(k-1-d) +: 8];
						if (probe != want)
							hit = 1'b0;
					end
					start = text_pos - index_t'(k - 1);
				end

				if (hit && !reported) begin
					reported = 1'b1;
					expected_results.push_back(search_result_t'{found: 1'b1, start: start});
				end else if (text_mon.final_byte && !reported) begin
					expected_results.push_back(search_result_t'{found: 1'b0, start: '0});
				end

				if (text_mon.final_byte) begin
					history = '{default: '0};
					text_pos = '0;
					reported = 1'b0;
				end else begin
					for (int d = MAX_NEEDLE - 2; d > 0; d--)
						history[d] = history[d-1];
					history[0] = text_mon.text_byte;
					if (text_pos != '1)
						text_pos++;
				end
			end
			pending = expected_results.size();
		end
	end

endmodule

// ===== dv/substring_first_match_search_test.sv =====
// ----------------------------------------------------------------------------
// substring_first_match_search_test: top of the substring search testbench
// Drives texts and needle settings into the block, applies flow control on
// both channels and reports the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module substring_first_match_search_test;
	timeunit 1ns;
	timeprecision 1ps;

	import sfms_pkg::*;

	localparam int MAX_NEEDLE   = 16;
	localparam int RANDOM_ITEMS = 800;
	localparam int PHASES       = 8;
	localparam int HOLD_CYCLES  = 400;     // long receiver hold-off
	localparam int DRAIN_LIMIT  = 5000;    // bound on waiting for results
	localparam int CYCLE_LIMIT  = 200000;  // run watchdog

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// plain config write port
	logic             cfg_we;
	logic [REG_W-1:0] cfg_index;
	word_t            cfg_wdata;

	sfms_text_if   text_ch ();
	sfms_result_if result_ch ();

	// flow-control knobs, changed between phases
	int   send_idle_pct = 0;
	int   stall_pct = 0;
	logic hold_go = 1'b0;

	// needle mirror used only to build texts that hit
	byte_t needle [MAX_NEEDLE];
	int    needle_used = 0;

	// byte alphabet: a small set makes partial and full matches frequent
	byte_t alpha [4];
	int    alpha_pct = 0;

	int cycles = 0;
	int texts_sent = 0;
	int bytes_sent = 0;

	int errors;
	int pending;
	int found_seen;
	int missed_seen;

	substring_first_match_search #(
		.MAX_NEEDLE(MAX_NEEDLE)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.text     (text_ch),
		.result   (result_ch)
	);

	first_match_checker #(
		.MAX_NEEDLE(MAX_NEEDLE)
	) match_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.text_mon   (text_ch),
		.result_mon (result_ch),
		.errors     (errors),
		.pending    (pending),
		.found_seen (found_seen),
		.missed_seen(missed_seen)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// watchdog: a hang anywhere ends the run as a failure
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Result side. Normally random stalls at stall_pct. Once hold_go is raised
	// ready is held low for HOLD_CYCLES, counted here, so the output register
	// fills and the block has to back-pressure the text channel.
	initial begin : receiver
		int held = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go && held < HOLD_CYCLES) begin
				result_ch.ready <= 1'b0;
				held++;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	function automatic byte_t pick_byte();
		if ($urandom_range(99) < alpha_pct)
			return alpha[$urandom_range(3)];
		return byte_t'($urandom);
	endfunction

	// One register write per edge; the caller drops cfg_we after its last one
	// so the enable never gets two assignments in the same step.
	task automatic write_reg(reg_index_t idx, word_t val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	// Offer one text byte, with random idle cycles before it, and return once
	// the transaction has been taken. Always entered and left at an edge.
	task automatic send_byte(byte_t b, logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			text_ch.valid <= 1'b0;
			@(posedge clk);
		end
		text_ch.valid <= 1'b1;
		text_ch.text_byte <= b;
		text_ch.final_byte <= last;
		@(posedge clk);
		while (!text_ch.ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_text(input byte_t t[$]);
		foreach (t[i])
			send_byte(t[i], i == t.size() - 1);
		texts_sent++;
	endtask

	// Go idle and wait until every predicted result has come out, then let
	// the output register drain as well: a byte that yields nothing may
	// still be in flight when the queue empties.
	task automatic settle();
		int waited = 0;
		text_ch.valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
	endtask

	// New random needle. len_code may exceed MAX_NEEDLE (block clamps it);
	// upper bits of the length write carry junk that must be ignored.
	task automatic load_needle(int len_code);
		word_t lo;
		word_t hi;
		word_t junk;
		for (int i = 0; i < MAX_NEEDLE; i++)
			needle[i] = pick_byte();
		for (int i = 0; i < NEEDLE_REG_BYTES; i++) begin
			lo[8*i +: 8] = needle[i];
			hi[8*i +: 8] = needle[i + NEEDLE_REG_BYTES];
		end
		needle_used = (len_code > MAX_NEEDLE) ? MAX_NEEDLE : len_code;
		junk = {$urandom, $urandom};
		if ($urandom_range(1))
			write_reg(REG_UNUSED, junk);
		write_reg(REG_NEEDLE_LOW, lo);
		write_reg(REG_NEEDLE_HIGH, hi);
		write_reg(REG_NEEDLE_LENGTH, (junk & ~word_t'(5'h1f)) | word_t'(len_code));
		cfg_we <= 1'b0;
	endtask

	// Random texts until about budget bytes have gone in. Half the texts that
	// can hold the needle get it planted (sometimes twice, so a later hit must
	// stay silent); short texts sometimes carry just a needle prefix.
	task automatic run_texts(int budget);
		byte_t t[$];
		int len;
		int at;
		int spent = 0;
		while (spent < budget) begin
			if ($urandom_range(9) == 0)
				len = $urandom_range(1, 60);
			else
				len = $urandom_range(1, needle_used + 8);
			t = {};
			for (int i = 0; i < len; i++)
				t.push_back(pick_byte());
			if (needle_used != 0 && len >= needle_used && $urandom_range(1)) begin
				repeat ($urandom_range(1, 2)) begin
					at = $urandom_range(0, len - needle_used);
					for (int i = 0; i < needle_used; i++)
						t[at + i] = needle[i];
				end
			end else if (len < needle_used && $urandom_range(1)) begin
				for (int i = 0; i < len; i++)
					t[i] = needle[i];
			end
			send_text(t);
			spent += len;
		end
	endtask

	initial begin : stimulus
		byte_t q[$];
		int len_code;
		cfg_we <= 1'b0;
		cfg_index <= REG_NEEDLE_LENGTH;
		cfg_wdata <= '0;
		text_ch.valid <= 1'b0;
		text_ch.text_byte <= '0;
		text_ch.final_byte <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed ----
		// reset needle is empty: every text hits at 0 on its first byte,
		// a one-byte text included, and nothing more comes from that text
		q = {8'h00};
		send_text(q);
		q = {8'hff, 8'h00};
		send_text(q);

		// two-byte needle 00 ff; the unused register index must be ignored
		settle();
		write_reg(REG_UNUSED, '1);
		write_reg(REG_NEEDLE_LOW, 64'h5a5a_5a5a_5a5a_ff00);
		write_reg(REG_NEEDLE_HIGH, '1);
		write_reg(REG_NEEDLE_LENGTH, 64'hffff_ffff_ffff_ffe2);
		cfg_we <= 1'b0;
		// hit at the start; the trailing byte stays silent
		q = {8'h00, 8'hff, 8'h00};
		send_text(q);
		// text shorter than the needle: not found on its only byte
		q = {8'h00};
		send_text(q);
		// match completed by the final byte: found, not a not-found
		q = {8'h11, 8'h00, 8'hff};
		send_text(q);

		// full 16-byte needle, text equal to it
		settle();
		write_reg(REG_NEEDLE_LOW, 64'hf7e6_d5c4_b3a2_9180);
		write_reg(REG_NEEDLE_HIGH, 64'h7f6e_5d4c_3b2a_1908);
		write_reg(REG_NEEDLE_LENGTH, 64'd16);
		cfg_we <= 1'b0;
		q = {};
		for (int i = 0; i < NEEDLE_REG_BYTES; i++)
			q.push_back(byte_t'(64'hf7e6_d5c4_b3a2_9180 >> (8*i)));
		for (int i = 0; i < NEEDLE_REG_BYTES; i++)
			q.push_back(byte_t'(64'h7f6e_5d4c_3b2a_1908 >> (8*i)));
		send_text(q);

		// ---- random phases ----
		// flow control cycles through none / sender idle / receiver stall /
		// both; needle length walks 1, 0, 31 (clamped), 16, 5 and random values
		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 64;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 64;
				end
				default: begin
					send_idle_pct = 30;
					stall_pct = 30;
				end
			endcase
			alpha[0] = byte_t'($urandom);
			alpha[1] = byte_t'($urandom);
			alpha[2] = p[0] ? 8'h00 : byte_t'($urandom);
			alpha[3] = p[1] ? 8'hff : byte_t'($urandom);
			// one phase uses fully random bytes, hits then come from planting
			alpha_pct = (p == 5) ? 0 : 85;
			case (p)
				0: len_code = 1;
				1: len_code = 0;
				2: len_code = 31;
				3: len_code = 16;
				4: len_code = 5;
				5: len_code = $urandom_range(2, 15);
				6: len_code = $urandom_range(17, 30);
				default: len_code = $urandom_range(1, 16);
			endcase
			load_needle(len_code);
			// first phase: receiver holds off while bytes keep coming
			if (p == 0)
				hold_go <= 1'b1;
			run_texts(RANDOM_ITEMS / PHASES);
		end

		settle();
		$display("Run covered %0d texts, %0d text bytes, %0d needle settings",
			texts_sent, bytes_sent, PHASES + 3);
		$display("Checked %0d found and %0d not-found results under four flow modes",
			found_seen, missed_seen);
		if (pending != 0)
			$display("%0d expected results never arrived", pending);
		if (errors == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
